>>> hdl/scms_pkg.sv
package scms_pkg;

   localparam int MAX_DIM     = 64;
   localparam int DIM_W       = $clog2(MAX_DIM) + 1;
   localparam int POS_W       = $clog2(MAX_DIM);
   localparam int DEPTH       = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int COST_W      = 32;
   localparam int COLOR_W     = 24;
   localparam int DIFF_W      = 18;
   localparam int ENERGY_W    = 16;
   localparam int CSR_ADDR_W  = 2;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FWD    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_HMODE  = 2'd3;

   typedef enum logic [2:0] {
      ST_LOAD, ST_PRE, ST_FILL, ST_SCAN, ST_OUT, ST_TRACE
   } state_type;

   // neighbor of (row, col) that an address refers to
   typedef enum logic [2:0] {
      SEL_HERE, SEL_NMID, SEL_NLEFT, SEL_NRIGHT, SEL_LEFT, SEL_RIGHT
   } sel_type;

   typedef enum logic [2:0] {
      CAP_NONE, CAP_HERE, CAP_MID, CAP_LEFT, CAP_RIGHT
   } cap_type;

   typedef enum logic [1:0] {
      CC_NONE, CC_LEFT, CC_RIGHT, CC_NMID
   } ccap_type;

   typedef enum logic [1:0] {
      DF_NONE, DF_LR, DF_LN, DF_RN
   } diff_type;

   typedef struct packed {
      logic              req_ready;
      sel_type           cost_sel;
      sel_type           color_sel;
      cap_type           cap;
      ccap_type          ccap;
      diff_type          diff;
      logic              prelim;
      logic              best_en;
      logic              write_en;
      logic              scan_cmp;
      logic              trace_step;
      logic              use_pos;
      logic              out_load;
      logic              out_last;
      logic [DIM_W-1:0]  row;
      logic [DIM_W-1:0]  col;
   } cmd_type;

   typedef struct packed {
      logic              load_last;
      logic              out_free;
      logic [DIM_W-1:0]  rows;
      logic [DIM_W-1:0]  cols;
   } status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      if (v < DIM_W'(2)) return DIM_W'(2);
      if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
      return v;
   endfunction

   // store address of a neighbor in the possibly transposed view
   function automatic logic [ADDR_W-1:0] sel_addr(input sel_type sel,
                                                  input logic [DIM_W-1:0] row,
                                                  input logic [DIM_W-1:0] col,
                                                  input logic [DIM_W-1:0] w,
                                                  input logic hmode);
      logic [DIM_W-1:0]   rr;
      logic [DIM_W-1:0]   cc;
      logic [2*DIM_W-1:0] idx;
      rr = row;
      cc = col;
      case (sel)
         SEL_HERE:   begin rr = row;             cc = col;             end
         SEL_NMID:   begin rr = row + DIM_W'(1); cc = col;             end
         SEL_NLEFT:  begin rr = row + DIM_W'(1); cc = col - DIM_W'(1); end
         SEL_NRIGHT: begin rr = row + DIM_W'(1); cc = col + DIM_W'(1); end
         SEL_LEFT:   begin rr = row;             cc = col - DIM_W'(1); end
         SEL_RIGHT:  begin rr = row;             cc = col + DIM_W'(1); end
         default:    begin rr = row;             cc = col;             end
      endcase
      if (hmode) idx = cc * w + {{DIM_W{1'b0}}, rr};
      else       idx = rr * w + {{DIM_W{1'b0}}, cc};
      return idx[ADDR_W-1:0];
   endfunction

   function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   function automatic logic [DIFF_W-1:0] color_diff(input logic [COLOR_W-1:0] p,
                                                    input logic [COLOR_W-1:0] q);
      return DIFF_W'(chan_sq(p[23:16], q[23:16])) + DIFF_W'(chan_sq(p[15:8], q[15:8]))
           + DIFF_W'(chan_sq(p[7:0], q[7:0]));
   endfunction

endpackage

>>> hdl/scms_ctrl.sv
module scms_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_fire,
   input  scms_pkg::status_type  st,
   output scms_pkg::cmd_type     cmd
);
   import scms_pkg::*;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [2:0]        ph_ff, ph_in;

   logic              row_end;
   assign row_end = (col_ff == st.cols - DIM_W'(1));

   // advance state and loop counters
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      ph_in    = ph_ff;
      case (state_ff)
         ST_LOAD: begin
            if (in_fire && st.load_last) begin
               state_in = ST_PRE;
               row_in   = st.rows - DIM_W'(1);
               col_in   = '0;
               ph_in    = '0;
            end
         end
         ST_PRE, ST_FILL: begin
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd7) begin
               col_in = col_ff + DIM_W'(1);
               if (row_end) begin
                  col_in = '0;
                  if (state_ff == ST_PRE) begin
                     state_in = ST_FILL;
                     row_in   = st.rows - DIM_W'(2);
                  end else if (row_ff == '0) begin
                     state_in = ST_SCAN;
                  end else begin
                     row_in = row_ff - DIM_W'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            ph_in = {2'b00, ~ph_ff[0]};
            if (ph_ff[0]) begin
               col_in = col_ff + DIM_W'(1);
               if (row_end) begin
                  state_in = ST_OUT;
                  row_in   = '0;
                  ph_in    = '0;
               end
            end
         end
         ST_OUT: begin
            if (st.out_free) begin
               ph_in = '0;
               if (row_ff == st.rows - DIM_W'(1)) state_in = ST_LOAD;
               else state_in = ST_TRACE;
            end
         end
         ST_TRACE: begin
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               state_in = ST_OUT;
               row_in   = row_ff + DIM_W'(1);
               ph_in    = '0;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // drive datapath commands
   always_comb begin
      cmd            = '0;
      cmd.cost_sel   = SEL_HERE;
      cmd.color_sel  = SEL_HERE;
      cmd.cap        = CAP_NONE;
      cmd.ccap       = CC_NONE;
      cmd.diff       = DF_NONE;
      cmd.row        = row_ff;
      cmd.col        = col_ff;
      case (state_ff)
         ST_LOAD: cmd.req_ready = 1'b1;
         ST_PRE, ST_FILL: begin
            cmd.prelim = (state_ff == ST_PRE);
            case (ph_ff)
               3'd0: begin cmd.cost_sel = SEL_HERE;   cmd.color_sel = SEL_LEFT; end
               3'd1: begin
                  cmd.cost_sel = SEL_NMID; cmd.color_sel = SEL_RIGHT;
                  cmd.cap = CAP_HERE; cmd.ccap = CC_LEFT;
               end
               3'd2: begin
                  cmd.cost_sel = SEL_NLEFT; cmd.color_sel = SEL_NMID;
                  cmd.cap = CAP_MID; cmd.ccap = CC_RIGHT;
               end
               3'd3: begin
                  cmd.cost_sel = SEL_NRIGHT; cmd.cap = CAP_LEFT;
                  cmd.ccap = CC_NMID; cmd.diff = DF_LR;
               end
               3'd4: begin cmd.cap = CAP_RIGHT; cmd.diff = DF_LN; end
               3'd5: cmd.diff = DF_RN;
               3'd6: cmd.best_en = 1'b1;
               3'd7: begin cmd.cost_sel = SEL_HERE; cmd.write_en = 1'b1; end
               default: ;
            endcase
         end
         ST_SCAN: begin
            cmd.row      = '0;
            cmd.cost_sel = SEL_HERE;
            cmd.scan_cmp = ph_ff[0];
         end
         ST_OUT: begin
            cmd.out_load = st.out_free;
            cmd.out_last = (row_ff == st.rows - DIM_W'(1));
         end
         ST_TRACE: begin
            cmd.use_pos = 1'b1;
            case (ph_ff)
               3'd0: cmd.cost_sel = SEL_NLEFT;
               3'd1: begin cmd.cost_sel = SEL_NMID;   cmd.cap = CAP_LEFT; end
               3'd2: begin cmd.cost_sel = SEL_NRIGHT; cmd.cap = CAP_MID;  end
               3'd3: cmd.cap = CAP_RIGHT;
               3'd4: cmd.trace_step = 1'b1;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         row_ff   <= '0;
         col_ff   <= '0;
         ph_ff    <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         ph_ff    <= ph_in;
      end
   end

endmodule

>>> hdl/scms_dp.sv
module scms_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  scms_pkg::cmd_type                   cmd,
   output scms_pkg::status_type                st,
   input  logic                                in_fire,
   input  logic [scms_pkg::ENERGY_W-1:0]       in_energy,
   input  logic [7:0]                          in_red,
   input  logic [7:0]                          in_green,
   input  logic [7:0]                          in_blue,
   input  logic                                csr_we,
   input  logic [scms_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [scms_pkg::DIM_W-1:0]          csr_wdata,
   output logic                                out_valid,
   output logic [scms_pkg::POS_W-1:0]          out_pos,
   output logic                                out_last,
   input  logic                                out_ready
);
   import scms_pkg::*;

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic               fwd_ff, hmode_ff;
   logic [ADDR_W-1:0]  load_count_ff, load_count_in;

   logic [COST_W-1:0]  cost_mem  [DEPTH];
   logic [COLOR_W-1:0] color_mem [DEPTH];
   logic [COST_W-1:0]  cost_rd_ff;
   logic [COLOR_W-1:0] color_rd_ff;

   logic [COST_W-1:0]  here_ff, mid_ff, left_ff, right_ff, best_ff, best_in, scan_ff;
   logic [COLOR_W-1:0] cl_ff, cr_ff, cn_ff;
   logic [DIFF_W-1:0]  cu_ff, dl_ff, dr_ff, diff_val;
   logic [POS_W-1:0]   pos_ff;
   logic               out_valid_ff, out_last_ff;
   logic [POS_W-1:0]   out_pos_ff;

   logic [DIM_W-1:0]   w, h, rows, cols, col_use;
   logic [2*DIM_W-1:0] area;
   logic [ADDR_W:0]    total;
   logic [ADDR_W-1:0]  cost_addr, color_addr, wr_addr;
   logic [COST_W-1:0]  wr_data;

   assign w     = clamp_dim(width_ff);
   assign h     = clamp_dim(height_ff);
   assign rows  = hmode_ff ? w : h;
   assign cols  = hmode_ff ? h : w;
   assign area  = w * h;
   assign total = area[ADDR_W:0];

   assign load_count_in = load_count_ff + ADDR_W'(1);
   assign st.load_last  = (load_count_in == '0) || ({1'b0, load_count_in} >= total);
   assign st.out_free   = !out_valid_ff || out_ready;
   assign st.rows       = rows;
   assign st.cols       = cols;

   assign col_use    = cmd.use_pos ? {1'b0, pos_ff} : cmd.col;
   assign cost_addr  = sel_addr(cmd.cost_sel, cmd.row, col_use, w, hmode_ff);
   assign color_addr = sel_addr(cmd.color_sel, cmd.row, col_use, w, hmode_ff);
   assign wr_addr    = in_fire ? load_count_ff : cost_addr;
   assign wr_data    = in_fire ? COST_W'(in_energy) : here_ff + best_ff;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_DIM);
         height_ff <= DIM_W'(MAX_DIM);
         fwd_ff    <= 1'b0;
         hmode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_WIDTH:  width_ff  <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata;
            REG_FWD:    fwd_ff    <= csr_wdata[0];
            REG_HMODE:  hmode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // count loaded pixels, restart after the image is complete
   always_ff @(posedge clock) begin
      if (reset) load_count_ff <= '0;
      else if (in_fire) load_count_ff <= st.load_last ? '0 : load_count_in;
   end

   // cost and color stores
   always_ff @(posedge clock) begin
      if (in_fire || cmd.write_en) cost_mem[wr_addr] <= wr_data;
      cost_rd_ff <= cost_mem[cost_addr];
   end

   always_ff @(posedge clock) begin
      if (in_fire) color_mem[load_count_ff] <= {in_red, in_green, in_blue};
      color_rd_ff <= color_mem[color_addr];
   end

   // capture read data into operand registers
   always_ff @(posedge clock) begin
      case (cmd.cap)
         CAP_HERE:  here_ff  <= cost_rd_ff;
         CAP_MID:   mid_ff   <= cost_rd_ff;
         CAP_LEFT:  left_ff  <= cost_rd_ff;
         CAP_RIGHT: right_ff <= cost_rd_ff;
         default: ;
      endcase
      case (cmd.ccap)
         CC_LEFT:  cl_ff <= color_rd_ff;
         CC_RIGHT: cr_ff <= color_rd_ff;
         CC_NMID:  cn_ff <= color_rd_ff;
         default: ;
      endcase
   end

   // one shared color difference unit
   always_comb begin
      case (cmd.diff)
         DF_LR:   diff_val = color_diff(cl_ff, cr_ff);
         DF_LN:   diff_val = color_diff(cl_ff, cn_ff);
         DF_RN:   diff_val = color_diff(cr_ff, cn_ff);
         default: diff_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.diff)
         DF_LR: cu_ff <= diff_val;
         DF_LN: dl_ff <= diff_val;
         DF_RN: dr_ff <= diff_val;
         default: ;
      endcase
   end

   // pick the cheapest neighbor below
   logic               lv, rv;
   logic [COST_W-1:0]  cu_e, dl_e, dr_e, m_c, l_c, r_c;
   always_comb begin
      lv      = (cmd.col != '0);
      rv      = (cmd.col != cols - DIM_W'(1));
      cu_e    = (fwd_ff && lv && rv) ? COST_W'(cu_ff) : '0;
      dl_e    = fwd_ff ? COST_W'(dl_ff) : '0;
      dr_e    = fwd_ff ? COST_W'(dr_ff) : '0;
      m_c     = mid_ff + cu_e;
      l_c     = left_ff + cu_e + dl_e;
      r_c     = right_ff + cu_e + dr_e;
      best_in = m_c;
      if (lv && l_c < best_in) best_in = l_c;
      if (rv && r_c < best_in) best_in = r_c;
      if (cmd.prelim) best_in = cu_e;
   end

   always_ff @(posedge clock) begin
      if (cmd.best_en) best_ff <= best_in;
   end

   // start scan and backtrack
   logic tlv, trv, go_left, go_right;
   always_comb begin
      tlv      = (pos_ff != '0);
      trv      = ({1'b0, pos_ff} != cols - DIM_W'(1));
      go_left  = tlv && (left_ff <= mid_ff) && (!trv || left_ff <= right_ff);
      go_right = !go_left && trv && (right_ff <= mid_ff) && (!tlv || right_ff <= left_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_cmp) begin
         if (cmd.col == '0 || cost_rd_ff < scan_ff) begin
            scan_ff <= cost_rd_ff;
            pos_ff  <= cmd.col[POS_W-1:0];
         end
      end else if (cmd.trace_step) begin
         if (go_left) pos_ff <= pos_ff - POS_W'(1);
         else if (go_right) pos_ff <= pos_ff + POS_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_pos_ff  <= pos_ff;
         out_last_ff <= cmd.out_last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pos   = out_pos_ff;
   assign out_last  = out_last_ff;

endmodule

>>> hdl/seam_carving_min_seam.sv
// Channel   | Direction | Signals                    | Content
// req_      | in        | tvalid tready tdata[39:0]  | one pixel per request
// rsp_      | out       | tvalid tready tdata[7:0]   | one seam position per row, tlast
// csr_      | in        | we addr[1:0] wdata[6:0]    | width, height, forward, horizontal
//
// Pixels load at one per cycle. After the last pixel of an image the block fills the
// cost table entry by entry (last-row pass plus rows-1 fill rows, cols entries each),
// then scans the first row for the start and backtracks one seam row at a time,
// limited by the single read port of the cost memory. Requests are refused while
// a run is in progress. Reset is synchronous; memory contents are not cleared.
// The output register lets the block stall on rsp_tready without losing data.
module seam_carving_min_seam (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pixel_energy[15:0], red[23:16], green[31:24], blue[39:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // seam_position[5:0], zero[7:6]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [6:0]  csr_wdata
);
   import scms_pkg::*;

   cmd_type             cmd;
   status_type          st;
   logic                in_fire;
   logic [POS_W-1:0]    pos;

   assign req_tready = cmd.req_ready;
   assign in_fire    = req_tvalid && cmd.req_ready;

   scms_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .st      (st),
      .cmd     (cmd)
   );

   scms_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .in_fire   (in_fire),
      .in_energy (req_tdata[15:0]),
      .in_red    (req_tdata[23:16]),
      .in_green  (req_tdata[31:24]),
      .in_blue   (req_tdata[39:32]),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .out_valid (rsp_tvalid),
      .out_pos   (pos),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {2'b00, pos};

endmodule

>>> hdl/scms_checker.sv
module scms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // seam end is followed by a quiet output
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result after end of seam");

   // no pixel taken while the output drives a seam mid-run
   a_no_load_mid_seam: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("pixel accepted during seam output");

endmodule

bind seam_carving_min_seam scms_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
